// ===== rtl/pa_gain_ramp_macros.svh =====
// Assertion macros used by the checker file of the gain ramp block.
// Depends on nothing; include by bare file name.
`ifndef PA_GAIN_RAMP_MACROS_SVH
`define PA_GAIN_RAMP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PGR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define PGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pgr_pkg.sv =====
// Package of the gain ramp block: widths, register indexes, defaults and
// the control struct passed to the ramp index unit. No dependencies.
package pgr_pkg;

    localparam int GAIN_W     = 16;  // unsigned Q2.14 gain
    localparam int GAIN_FRAC  = 14;
    localparam int STEPS_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_RAMP_STEPS = 1024;
    localparam int DEF_SAMPLE_WIDTH   = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'b1;

    localparam logic [GAIN_W-1:0]  STEP_GAIN_RST  = 16'd0;
    localparam logic [STEPS_W-1:0] STEP_COUNT_RST = 11'd1;

    typedef struct packed {
        logic tag_load;  // request with a tag accepted this cycle
        logic tag_on;    // tag value: ramp up when set
        logic advance;   // result handed on: step the ramp
    } ramp_ctrl_t;

endpackage

// ===== rtl/pgr_mul.sv =====
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on pgr_pkg.
module pgr_mul
    import pgr_pkg::*;
#(
    parameter int A_W = DEF_SAMPLE_WIDTH
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    op_a,
    input  logic [GAIN_W-1:0]        op_b,
    output logic signed [A_W+GAIN_W:0] prod
);

    logic signed [A_W+GAIN_W:0] prod_reg;
    logic signed [A_W+GAIN_W:0] prod_next;

    assign prod_next = op_a * $signed({1'b0, op_b});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/pgr_ramp.sv =====
// Ramp index and direction flags: tag handling and per-sample stepping.
// Depends on pgr_pkg.
module pgr_ramp
    import pgr_pkg::*;
#(
    parameter int MAX_RAMP_STEPS = DEF_MAX_RAMP_STEPS,
    parameter int IDX_W          = $clog2(MAX_RAMP_STEPS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [STEPS_W-1:0] step_count,
    input  ramp_ctrl_t         ctrl,
    output logic [IDX_W-1:0]   ramp_index
);

    localparam int CW = (IDX_W > STEPS_W) ? IDX_W : STEPS_W;
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_RAMP_STEPS);

    logic [CW-1:0]    steps_ext;
    logic [CW-1:0]    steps_cw;
    logic [IDX_W-1:0] steps;
    logic [IDX_W-1:0] index_reg, index_next, idx_adv;
    logic             up_reg, up_next, up_adv;
    logic             down_reg, down_next, down_adv;

    // Clamp the step count into 1 .. MAX_RAMP_STEPS
    always_comb begin
        steps_ext = CW'(step_count);
        if (steps_ext == '0) begin
            steps_cw = CW'(1);
        end else if (steps_ext > MAX_CW) begin
            steps_cw = MAX_CW;
        end else begin
            steps_cw = steps_ext;
        end
        steps = IDX_W'(steps_cw);
    end

    // Advance after the previous result, then let a new tag override
    always_comb begin
        idx_adv  = index_reg;
        up_adv   = up_reg;
        down_adv = down_reg;
        if (ctrl.advance) begin
            if (up_reg) begin
                if (index_reg < steps) begin
                    idx_adv = index_reg + 1'b1;
                end
                if (idx_adv >= steps) begin
                    up_adv = 1'b0;
                end
            end else if (down_reg) begin
                if (index_reg != '0) begin
                    idx_adv = index_reg - 1'b1;
                end
                if (idx_adv == '0) begin
                    down_adv = 1'b0;
                end
            end
        end

        index_next = idx_adv;
        up_next    = up_adv;
        down_next  = down_adv;
        if (ctrl.tag_load) begin
            if (ctrl.tag_on) begin
                index_next = IDX_W'(1);
                if (steps > IDX_W'(1)) begin
                    up_next = 1'b1;
                end
            end else begin
                index_next = steps - 1'b1;
                if (steps > IDX_W'(1)) begin
                    down_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
        end else begin
            index_reg <= index_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
        end
    end

    assign ramp_index = index_reg;

endmodule

// ===== rtl/pa_gain_ramp.sv =====
// Top level of the power amplifier gain ramp: sequencer, configuration
// registers and output register. Depends on pgr_pkg, pgr_mul, pgr_ramp.
//
//  channel   group                      payload
//  --------  -------------------------  --------------------------------------
//  input     s_tvalid/s_tready          s_tdata: sample_i, sample_q
//                                       s_tuser: tag_valid, tag_on
//  output    m_tvalid/m_tready          m_tdata: out_i, out_q
//  config    cfg_we/cfg_idx/cfg_wdata   step_gain (0), step count (1)
//
// Each sample passes the one shared multiplier three times (index times
// step gain, I times gain, Q times gain); the next request is taken in the
// cycle its predecessor moves to the output register, and not before.
// Reset is synchronous, active low, and clears the sequencer, ramp state,
// output valid and the registers (step_gain 0, step count 1).
// A stall on m_tready holds the finished sample in the last cycle of work.
module pa_gain_ramp
    import pgr_pkg::*;
#(
    parameter int MAX_RAMP_STEPS = DEF_MAX_RAMP_STEPS,
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    localparam int TDATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sample_i, sample_q
    input  logic [1:0]            s_tuser,   // tag_valid, tag_on

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata    // out_i, out_q
);

    localparam int IDX_W = $clog2(MAX_RAMP_STEPS + 1);
    localparam int A_W   = (SAMPLE_WIDTH > IDX_W + 1) ? SAMPLE_WIDTH : IDX_W + 1;
    localparam int P_W   = A_W + GAIN_W + 1;
    localparam int SH_W  = P_W - GAIN_FRAC;
    localparam int HI_W  = SH_W - SAMPLE_WIDTH + 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GAIN  = 3'd1;  // index times step gain
    localparam logic [2:0] ST_MUL_I = 3'd2;  // saturate gain, I times gain
    localparam logic [2:0] ST_MUL_Q = 3'd3;  // Q times gain, keep I result
    localparam logic [2:0] ST_OUT   = 3'd4;  // hand result on

    logic [2:0] state_reg, state_next;

    logic [GAIN_W-1:0]  step_gain_reg;
    logic [STEPS_W-1:0] step_count_reg;

    logic signed [SAMPLE_WIDTH-1:0] samp_i_reg, samp_q_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_i_reg;
    logic [GAIN_W-1:0]              gain_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;

    logic s_accept;
    logic out_free;
    logic out_push;

    logic                    mul_en;
    logic signed [A_W-1:0]   op_a;
    logic [GAIN_W-1:0]       op_b;
    logic signed [P_W-1:0]   prod;

    logic [GAIN_W-1:0]              gain_sat;
    logic signed [SH_W-1:0]         shifted;
    logic [HI_W-1:0]                shifted_hi;
    logic signed [SAMPLE_WIDTH-1:0] samp_sat;

    logic [IDX_W-1:0] ramp_index;
    ramp_ctrl_t       ramp_ctrl;

    // Handshake: take a request when idle, or when the finished sample
    // leaves in this same cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_push = (state_reg == ST_OUT) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || out_push;
    assign s_accept = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_gain_reg  <= STEP_GAIN_RST;
            step_count_reg <= STEP_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_STEP_GAIN:  step_gain_reg  <= cfg_wdata;
                CFG_STEP_COUNT: step_count_reg <= cfg_wdata[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Ramp state: tag on the request, step once the result is handed on
    assign ramp_ctrl.tag_load = s_accept && s_tuser[0];
    assign ramp_ctrl.tag_on   = s_tuser[1];
    assign ramp_ctrl.advance  = out_push;

    pgr_ramp #(
        .MAX_RAMP_STEPS(MAX_RAMP_STEPS),
        .IDX_W         (IDX_W)
    ) u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_count(step_count_reg),
        .ctrl      (ramp_ctrl),
        .ramp_index(ramp_index)
    );

    // Gain saturates at full scale of Q2.14; the gain product is never negative
    assign gain_sat = (prod[P_W-1:GAIN_W] != '0) ? '1 : prod[GAIN_W-1:0];

    // Drop 14 fraction bits (floor), then clip to the signed sample range
    assign shifted    = prod[P_W-1:GAIN_FRAC];
    assign shifted_hi = shifted[SH_W-1:SAMPLE_WIDTH-1];
    always_comb begin
        if ((&shifted_hi) || !(|shifted_hi)) begin
            samp_sat = shifted[SAMPLE_WIDTH-1:0];
        end else if (shifted[SH_W-1]) begin
            samp_sat = SAMP_MIN;
        end else begin
            samp_sat = SAMP_MAX;
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            ST_GAIN: begin
                mul_en = 1'b1;
                op_a   = A_W'(ramp_index);
                op_b   = step_gain_reg;
            end
            ST_MUL_I: begin
                mul_en = 1'b1;
                op_a   = A_W'(samp_i_reg);
                op_b   = gain_sat;
            end
            ST_MUL_Q: begin
                mul_en = 1'b1;
                op_a   = A_W'(samp_q_reg);
                op_b   = gain_reg;
            end
            default: ;
        endcase
    end

    pgr_mul #(
        .A_W(A_W)
    ) u_mul (
        .aclk(aclk),
        .en  (mul_en),
        .op_a(op_a),
        .op_b(op_b),
        .prod(prod)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_Q;
            ST_MUL_Q: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = s_accept ? ST_GAIN : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sample and intermediate payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            samp_i_reg <= s_tdata[SAMPLE_WIDTH-1:0];
            samp_q_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
        if (state_reg == ST_MUL_I) begin
            gain_reg <= gain_sat;
        end
        if (state_reg == ST_MUL_Q) begin
            out_i_reg <= samp_sat;
        end
    end

    // Output register: hold under stall, drop valid once taken
    always_comb begin
        if (out_push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_tdata_reg <= TDATA_W'({samp_sat, out_i_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/pa_gain_ramp_chk.sv =====
// Port-level checker of the gain ramp block and its bind to the top level.
// Depends on pa_gain_ramp_macros.svh.
`include "pa_gain_ramp_macros.svh"

module pa_gain_ramp_chk #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // A stalled result must stay put
    `PGR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output request changed under stall")

    // The shared multiplier keeps the block from taking a request while it works on one
    `PGR_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready, "request taken while multiplier busy")

    // A result appearing on an empty output traces to a request taken before the gain, I, Q and output states
    `PGR_ASSERT_SAME(a_out_latency, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 5), "output request without matching input request")

endmodule

bind pa_gain_ramp pa_gain_ramp_chk #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_chk (.*);
